[rtl/core/svu_pkg.sv]
// svu_pkg: types, constants and fixed-point helpers for the stereo vu level meter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package svu_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int MAX_FRAME_LOG2_DEF = 16;

  localparam int SUM_W   = 64;
  localparam int LOG_W   = 24;
  localparam int DB_W    = 16;

  localparam logic signed [DB_W-1:0] DB_FLOOR = -16'sd15360;
  localparam logic signed [DB_W-1:0] DB_MIN   = -16'sd32768;
  localparam logic [17:0] K_DB10 = 18'd197283;

  localparam logic [15:0] GAIN_RST  = 16'd3542;
  localparam logic [11:0] DECAY_RST = 12'd77;

  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_DECAY = 2'd1;
  localparam logic [1:0] REG_MONO  = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic               last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] level_left;
    logic signed [15:0] level_right;
    logic signed [15:0] peak_left;
    logic signed [15:0] peak_right;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_NORM,
    ST_LOG,
    ST_DB_MUL,
    ST_DB_RND,
    ST_VU_MUL,
    ST_VU_RND,
    ST_NEXT,
    ST_HOLD,
    ST_OUT
  } state_t;

  // operand select for the shared end-of-frame unit
  typedef enum logic [2:0] {
    OP_SUM_L,
    OP_SUM_R,
    OP_COUNT,
    OP_MAX_L,
    OP_MAX_R
  } op_sel_t;

  typedef struct packed {
    logic    accum;
    logic    load_norm;
    op_sel_t op;
    logic    log_step;
    logic    db_mul;
    logic    db_round;
    logic    vu_mul;
    logic    vu_round;
    logic    hold_upd;
    logic    clear;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic log_done;
    logic frame_end;
  } status_t;

  function automatic logic signed [DB_W-1:0] clamp_db(input logic signed [47:0] v);
    if (v > 48'sd0) begin
      return '0;
    end
    if (v < -48'sd32768) begin
      return DB_MIN;
    end
    return v[DB_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/svu_ctrl.sv]
// svu_ctrl: sequencer for accumulate and the end-of-frame log, dB and vu steps
// depends on svu_pkg
`timescale 1ns / 1ps
`default_nettype none
module svu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire svu_pkg::status_t sts,
  output svu_pkg::cmd_t         cmd
);
  import svu_pkg::*;

  state_t state_r, state_nxt;
  // which log operand: 0 sum, 1 count, 2 max ; ch 0 left 1 right
  logic [1:0] kind_r, kind_nxt;
  logic       ch_r, ch_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      kind_r      <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_ACCUM: begin
        if (in_valid && sts.frame_end) begin
          state_nxt = ST_NORM;
          kind_nxt  = 2'd0;
          ch_nxt    = 1'b0;
        end
      end
      ST_NORM:  state_nxt = ST_LOG;
      ST_LOG: begin
        if (sts.log_done) begin
          if (kind_r == 2'd0) begin
            kind_nxt  = 2'd1;
            state_nxt = ST_NORM;
          end else begin
            state_nxt = ST_DB_MUL;
          end
        end
      end
      ST_DB_MUL: state_nxt = ST_DB_RND;
      ST_DB_RND: state_nxt = (kind_r == 2'd2) ? ST_HOLD : ST_VU_MUL;
      ST_VU_MUL: state_nxt = ST_VU_RND;
      ST_VU_RND: state_nxt = ST_NEXT;
      ST_HOLD:   state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          kind_nxt  = (kind_r == 2'd2) ? 2'd2 : 2'd0;
          state_nxt = ST_NORM;
        end else if (kind_r != 2'd2) begin
          ch_nxt    = 1'b0;
          kind_nxt  = 2'd2;
          state_nxt = ST_NORM;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    // the count log is selected only while it runs; scaling and vu steps
    // after it act on the channel's sum
    unique case (kind_r)
      2'd0:    cmd.op = ch_r ? OP_SUM_R : OP_SUM_L;
      2'd1:    cmd.op = (state_r == ST_NORM || state_r == ST_LOG) ? OP_COUNT
                        : (ch_r ? OP_SUM_R : OP_SUM_L);
      default: cmd.op = ch_r ? OP_MAX_R : OP_MAX_L;
    endcase
    unique case (state_r)
      ST_ACCUM: begin
        in_stall  = 1'b0;
        cmd.accum = in_valid;
      end
      ST_NORM:   cmd.load_norm = 1'b1;
      ST_LOG:    cmd.log_step  = 1'b1;
      ST_DB_MUL: cmd.db_mul    = 1'b1;
      ST_DB_RND: cmd.db_round  = 1'b1;
      ST_VU_MUL: cmd.vu_mul    = 1'b1;
      ST_VU_RND: cmd.vu_round  = 1'b1;
      ST_HOLD:   cmd.hold_upd  = 1'b1;
      ST_NEXT:   ;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          cmd.clear     = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/svu_dp.sv]
// svu_dp: accumulators, shared log2 unit, dB scaling, vu integrator and peak hold
// depends on svu_pkg
`timescale 1ns / 1ps
`default_nettype none
module svu_dp #(
  parameter int SAMPLE_BITS    = svu_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_FRAME_LOG2 = svu_pkg::MAX_FRAME_LOG2_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire svu_pkg::in_item_t in_data,
  input  wire logic [15:0]       gain,
  input  wire logic [11:0]       decay,
  input  wire logic              mono,
  input  wire svu_pkg::cmd_t     cmd,
  output svu_pkg::status_t       sts,
  output svu_pkg::out_item_t     out_data
);
  import svu_pkg::*;

  localparam int CNT_W = MAX_FRAME_LOG2 + 1;
  localparam int MAG_W = SAMPLE_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int E_W   = 6;

  logic [SUM_W-1:0] sum_l_r, sum_r_r;
  logic [MAG_W-1:0] max_l_r, max_r_r;
  logic [CNT_W-1:0] cnt_r;

  logic [MAG_W-1:0] mag_l, mag_r;
  logic [SQ_W-1:0]  sq_l, sq_r;
  logic [CNT_W-1:0] cnt_inc;
  logic [SUM_W:0]   add_l, add_r;

  // magnitude of the low SAMPLE_BITS bits, as unsigned
  function automatic logic [MAG_W-1:0] mag_of(input logic [15:0] raw);
    logic [MAG_W-1:0] v;
    v = MAG_W'(raw);
    if (v[MAG_W-1]) begin
      return MAG_W'(-v);
    end
    return v;
  endfunction

  assign mag_l   = mag_of(in_data.sample_left);
  assign mag_r   = mono ? mag_l : mag_of(in_data.sample_right);
  assign sq_l    = SQ_W'(mag_l) * SQ_W'(mag_l);
  assign sq_r    = SQ_W'(mag_r) * SQ_W'(mag_r);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign add_l   = {1'b0, sum_l_r} + (SUM_W+1)'(sq_l);
  assign add_r   = {1'b0, sum_r_r} + (SUM_W+1)'(sq_r);

  assign sts.frame_end = in_data.last_in_frame || cnt_inc[CNT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
      max_l_r <= '0;
      max_r_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.accum) begin
      sum_l_r <= add_l[SUM_W] ? '1 : add_l[SUM_W-1:0];
      sum_r_r <= add_r[SUM_W] ? '1 : add_r[SUM_W-1:0];
      if (mag_l > max_l_r) begin
        max_l_r <= mag_l;
      end
      if (mag_r > max_r_r) begin
        max_r_r <= mag_r;
      end
      cnt_r <= cnt_inc;
    end
  end

  // ---- shared log2 unit: one fraction bit per cycle
  logic [SUM_W-1:0] opnd;
  logic [E_W-1:0]   lead;
  logic [32:0]      m_r;
  logic [65:0]      msq;
  logic [32:0]      mnew;
  logic [15:0]      frac_r;
  logic [E_W-1:0]   e_r;
  logic [4:0]       it_r;
  logic             zero_r;
  logic signed [LOG_W+1:0] lsum_r;
  logic [94:0]      shl;

  always_comb begin
    unique case (cmd.op)
      OP_SUM_L: opnd = sum_l_r;
      OP_SUM_R: opnd = sum_r_r;
      OP_COUNT: opnd = SUM_W'(cnt_r);
      OP_MAX_L: opnd = SUM_W'(max_l_r);
      OP_MAX_R: opnd = SUM_W'(max_r_r);
      default:  opnd = '0;
    endcase
  end

  // leading one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (opnd[i]) begin
        lead = E_W'(i);
      end
    end
  end

  assign shl  = {31'd0, opnd} << (7'd31 + 7'(63 - lead));
  assign msq  = 66'(m_r) * 66'(m_r);
  assign mnew = msq[63:31];

  assign sts.log_done = (it_r == 5'd16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else if (cmd.load_norm) begin
      it_r <= '0;
    end else if (cmd.log_step && it_r != 5'd16) begin
      it_r <= it_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_norm) begin
      m_r    <= {1'b0, shl[94:63]};
      e_r    <= lead;
      frac_r <= '0;
      if (cmd.op != OP_COUNT) begin
        zero_r <= (opnd == '0);
      end
    end else if (cmd.log_step && it_r != 5'd16) begin
      frac_r <= {frac_r[14:0], mnew[32]};
      m_r    <= mnew[32] ? {1'b0, mnew[32:1]} : mnew;
    end
  end

  logic signed [LOG_W+1:0] lval;
  assign lval = $signed({4'b0000, e_r, frac_r});

  // first log of a channel is the numerator; count log subtracts
  // log_done meets log_step once per log
  always_ff @(posedge clk) begin
    if (cmd.log_step && sts.log_done) begin
      if (cmd.op == OP_COUNT) begin
        lsum_r <= lsum_r - lval - (LOG_W+2)'(2 * (SAMPLE_BITS - 1) * 65536);
      end else if (cmd.op == OP_MAX_L || cmd.op == OP_MAX_R) begin
        lsum_r <= lval - (LOG_W+2)'((SAMPLE_BITS - 1) * 65536);
      end else begin
        lsum_r <= lval;
      end
    end
  end

  // ---- dB scaling and vu / hold update
  logic signed [47:0] prod_r;
  logic signed [DB_W-1:0] lvl_r;
  logic signed [DB_W-1:0] vu_l_r, vu_r_r, hold_l_r, hold_r_r;
  logic signed [DB_W-1:0] vu_cur, hold_cur;
  logic signed [17:0] diff;
  logic signed [47:0] rsh;
  logic signed [47:0] vsum;
  logic signed [17:0] hdec;
  logic is_peak, is_right;
  logic signed [19:0] kmul;

  assign is_peak  = (cmd.op == OP_MAX_L) || (cmd.op == OP_MAX_R);
  assign is_right = (cmd.op == OP_SUM_R) || (cmd.op == OP_MAX_R);
  assign kmul     = is_peak ? $signed({1'b0, K_DB10, 1'b0}) : $signed({2'b00, K_DB10});
  assign vu_cur   = is_right ? vu_r_r : vu_l_r;
  assign hold_cur = is_right ? hold_r_r : hold_l_r;
  assign diff     = 18'(lvl_r) - 18'(vu_cur);
  assign rsh      = (prod_r + 48'sd32768) >>> 16;
  assign vsum     = 48'(vu_cur) + rsh;
  assign hdec     = 18'(hold_cur) - $signed({6'd0, decay});

  logic signed [DB_W-1:0] lvl_calc;
  always_comb begin
    lvl_calc = clamp_db((prod_r + 48'sd8388608) >>> 24);
    if (zero_r) begin
      lvl_calc = DB_FLOOR;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.db_mul) begin
      prod_r <= 48'(lsum_r) * 48'(kmul);
    end else if (cmd.vu_mul) begin
      prod_r <= 48'(diff) * $signed({32'd0, gain});
    end
    if (cmd.db_round) begin
      lvl_r <= lvl_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vu_l_r   <= DB_FLOOR;
      vu_r_r   <= DB_FLOOR;
      hold_l_r <= DB_FLOOR;
      hold_r_r <= DB_FLOOR;
    end else begin
      if (cmd.vu_round) begin
        if (is_right) vu_r_r <= clamp_db(vsum);
        else          vu_l_r <= clamp_db(vsum);
      end
      if (cmd.hold_upd) begin
        logic signed [DB_W-1:0] hv;
        hv = (lvl_r > hold_cur) ? lvl_r :
             (hdec < -18'sd32768) ? DB_MIN : hdec[DB_W-1:0];
        if (is_right) hold_r_r <= hv;
        else          hold_l_r <= hv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.level_left  <= vu_l_r;
      out_data.level_right <= vu_r_r;
      out_data.peak_left   <= hold_l_r;
      out_data.peak_right  <= hold_r_r;
    end
  end

endmodule
`default_nettype wire

[rtl/core/stereo_vu_level_meter.sv]
// stereo_vu_level_meter: top level, apb register file, controller and datapath
// depends on svu_pkg, svu_ctrl, svu_dp
`timescale 1ns / 1ps
`default_nettype none
// Stereo VU meter. One sample pair is a transaction of one cycle on the
// input channel; a pair that is not the end of a frame is taken every cycle.
// At frame end the block stalls input while a single shared log2 unit (one
// fraction bit a cycle: a normalize step, then 16 steps and a hand-off per
// log) works through, for each channel, the square sum and the pair count,
// then dB scaling and the VU integrator; then the two peaks, each with dB
// scaling and the peak hold. Then one result transaction leaves through
// an output register. Registers at byte addresses 0 (gain), 4 (decay step),
// 8 (mono): the user must write them only while the block is idle; the
// block itself does not enforce it.
module stereo_vu_level_meter #(
  parameter int SAMPLE_BITS    = svu_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_FRAME_LOG2 = svu_pkg::MAX_FRAME_LOG2_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire svu_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output svu_pkg::out_item_t      out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [3:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import svu_pkg::*;

  logic [15:0] gain_r;
  logic [11:0] decay_r;
  logic        mono_r;
  logic [1:0]  ridx;
  cmd_t        cmd;
  status_t     sts;

  assign cfg_pready = 1'b1;
  assign ridx       = cfg_paddr[3:2];

  // register write on the apb access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      decay_r <= DECAY_RST;
      mono_r  <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        REG_GAIN:  gain_r  <= cfg_pwdata[15:0];
        REG_DECAY: decay_r <= cfg_pwdata[11:0];
        REG_MONO:  mono_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_GAIN:  cfg_prdata = {16'd0, gain_r};
      REG_DECAY: cfg_prdata = {20'd0, decay_r};
      REG_MONO:  cfg_prdata = {31'd0, mono_r};
      default:   cfg_prdata = '0;
    endcase
  end

  svu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  svu_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_FRAME_LOG2 (MAX_FRAME_LOG2)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .gain     (gain_r),
    .decay    (decay_r),
    .mono     (mono_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

[rtl/core/svu_checker.sv]
// svu_checker: port-level assertions for the stereo vu level meter
// depends on svu_pkg; bound to stereo_vu_level_meter
`timescale 1ns / 1ps
`default_nettype none
module svu_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire svu_pkg::out_item_t out_data
);
  import svu_pkg::*;

  // levels never go above 0 dB
  a_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.level_left[15] || out_data.level_left == 16'd0) &&
      (out_data.level_right[15] || out_data.level_right == 16'd0))
    else $error("level range");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result changed");

  // a rising result valid is preceded by an input stall
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)) else $error("input taken while finishing");

  // peak positive impossible
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.peak_left[15] || out_data.peak_left == 16'd0) &&
      (out_data.peak_right[15] || out_data.peak_right == 16'd0))
    else $error("peak above full scale");

  // a waiting input transaction stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("input withdrawn while stalled");

endmodule

bind stereo_vu_level_meter svu_checker u_svu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[tb/stereo_vu_level_meter_test.sv]
// stereo_vu_level_meter_test: self-checking bench for the stereo vu level meter
// depends on svu_pkg and stereo_vu_level_meter; drives frames, predicts levels, compares
`timescale 1ns / 1ps
`default_nettype none
module stereo_vu_level_meter_test;
  import svu_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  stereo_vu_level_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor copy of configuration and state
  logic [15:0] gain_q;
  logic [11:0] decay_q;
  logic mono_q;
  logic [63:0] sum_l, sum_r;
  logic [15:0] max_l, max_r;
  int unsigned pairs;
  int vu_l, vu_r, hold_l, hold_r;

  out_item_t level_queue[$];
  int errors = 0;

  function automatic logic [15:0] mag_of(logic [15:0] s);
    return s[15] ? 16'(17'h10000 - {1'b0, s}) : s;
  endfunction

  // log2 in q.16, truncated, by repeated squaring of a q1.31 mantissa
  function automatic longint log2_q16(logic [63:0] x);
    int e;
    logic [63:0] m;
    longint fr;
    e = 63;
    fr = 0;
    while (e > 0 && !x[e]) e--;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= 64'h1_0000_0000) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) <<< 16) + fr;
  endfunction

  // floor of (p + half) / 2^s
  function automatic longint rnd_shift(longint p, int s);
    longint q;
    q = p + (longint'(1) <<< (s - 1));
    return q >>> s;
  endfunction

  function automatic int sat_db(longint v);
    if (v > 0) return 0;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int mean_level(logic [63:0] s, int unsigned n);
    longint l;
    if (s == 0 || n == 0) return int'(DB_FLOOR);
    l = log2_q16(s) - log2_q16(64'(n)) - (longint'(30) <<< 16);
    return sat_db(rnd_shift(l * 197283, 24));
  endfunction

  function automatic int peak_level(logic [15:0] m);
    longint l;
    if (m == 0) return int'(DB_FLOOR);
    l = log2_q16(64'(m)) - (longint'(15) <<< 16);
    return sat_db(rnd_shift(l * 2 * 197283, 24));
  endfunction

  function automatic int vu_next(int v, int lvl);
    return sat_db(longint'(v) + rnd_shift((longint'(lvl) - v) * longint'(gain_q), 16));
  endfunction

  function automatic int hold_next(int h, int pk);
    if (pk > h) return pk;
    return (h - int'(decay_q) < -32768) ? -32768 : h - int'(decay_q);
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  // advance the predictor by one pair; returns 1 and the levels at frame end
  function automatic bit meter_pair(in_item_t it, output out_item_t r);
    logic [15:0] ml, mr;
    bit last;
    ml = mag_of(it.sample_left);
    mr = mono_q ? ml : mag_of(it.sample_right);
    sum_l = sat_sum(sum_l, 64'(ml) * 64'(ml));
    sum_r = sat_sum(sum_r, 64'(mr) * 64'(mr));
    if (ml > max_l) max_l = ml;
    if (mr > max_r) max_r = mr;
    pairs++;
    last = it.last_in_frame || pairs >= (1 << 16);
    r = '0;
    if (!last) return 1'b0;
    vu_l = vu_next(vu_l, mean_level(sum_l, pairs));
    vu_r = vu_next(vu_r, mean_level(sum_r, pairs));
    hold_l = hold_next(hold_l, peak_level(max_l));
    hold_r = hold_next(hold_r, peak_level(max_r));
    sum_l = 0; sum_r = 0; max_l = 0; max_r = 0; pairs = 0;
    r.level_left = 16'(vu_l);
    r.level_right = 16'(vu_r);
    r.peak_left = 16'(hold_l);
    r.peak_right = 16'(hold_r);
    return 1'b1;
  endfunction

  // random gap: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  bit stall_quiet = 1'b0;
  int stall_left = 0;

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_GAIN: gain_q = val[15:0];
      REG_DECAY: decay_q = val[11:0];
      REG_MONO: mono_q = val[0];
      default: ;
    endcase
  endtask

  // one input transaction; expected levels are queued before acceptance
  // valid stays up after acceptance unless a gap follows
  task automatic send_pair(in_item_t it, bit use_typed, out_item_t typed);
    out_item_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    if (meter_pair(it, r)) begin
      if (use_typed && r !== typed) begin
        $error("typed level mismatch: expected %h predictor %h", typed, r);
        errors++;
      end
      level_queue.push_back(use_typed ? typed : r);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (level_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // directed table: sample pair, whether the result is typed, typed result
  typedef struct {
    in_item_t it;
    bit typed;
    out_item_t res;
  } row_t;

  function automatic in_item_t mk(int l, int r, bit last);
    in_item_t it;
    it.sample_left = 16'(l);
    it.sample_right = 16'(r);
    it.last_in_frame = last;
    return it;
  endfunction

  task automatic random_frame(int max_len);
    int n, kind, amp;
    in_item_t it;
    n = $urandom_range(1, max_len);
    kind = $urandom_range(0, 3);
    amp = (kind == 0) ? 32768 : (kind == 1) ? 256 : (kind == 2) ? 4 : 1;
    for (int i = 0; i < n; i++) begin
      it.sample_left = (kind == 3 && $urandom_range(0, 1)) ? 16'h0000
                       : 16'($urandom_range(0, 2 * amp - 1) - amp);
      it.sample_right = (kind == 3) ? 16'($urandom) : 16'($urandom_range(0, 2 * amp - 1) - amp);
      it.last_in_frame = (i == n - 1);
      send_pair(it, 1'b0, '0);
    end
  endtask

  // result checking against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (level_queue.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        errors++;
      end else begin
        out_item_t e;
        e = level_queue.pop_front();
        if (out_data.level_left !== e.level_left) begin
          $error("level_left expected %0d actual %0d", e.level_left, out_data.level_left);
          errors++;
        end
        if (out_data.level_right !== e.level_right) begin
          $error("level_right expected %0d actual %0d", e.level_right, out_data.level_right);
          errors++;
        end
        if (out_data.peak_left !== e.peak_left) begin
          $error("peak_left expected %0d actual %0d", e.peak_left, out_data.peak_left);
          errors++;
        end
        if (out_data.peak_right !== e.peak_right) begin
          $error("peak_right expected %0d actual %0d", e.peak_right, out_data.peak_right);
          errors++;
        end
      end
    end
  end

  // receiver stall, mostly short runs, now and then long, with quiet stretches
  always @(negedge clk) begin
    if (stall_quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always begin
    stall_quiet = 1'b0;
    repeat ($urandom_range(200, 2000)) @(posedge clk);
    stall_quiet = 1'b1;
    repeat ($urandom_range(100, 600)) @(posedge clk);
  end

  initial begin
    row_t rows[$];
    out_item_t floor_res, full_res;
    gain_q = GAIN_RST; decay_q = DECAY_RST; mono_q = 1'b0;
    sum_l = 0; sum_r = 0; max_l = 0; max_r = 0; pairs = 0;
    vu_l = -15360; vu_r = -15360; hold_l = -15360; hold_r = -15360;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // silence after reset keeps everything at the -60 dB floor, hold decays
    floor_res = '{level_left: DB_FLOOR, level_right: DB_FLOOR,
                  peak_left: DB_FLOOR - 16'sd77, peak_right: DB_FLOOR - 16'sd77};
    // full-scale negative sample: 0 dB frame, vu moves one step up, 0 dB peak
    full_res = '{level_left: -16'sd14530, level_right: -16'sd14530,
                 peak_left: 16'sd0, peak_right: 16'sd0};
    rows.push_back('{mk(0, 0, 1), 1, floor_res});
    rows.push_back('{mk(-32768, -32768, 1), 1, full_res});
    rows.push_back('{mk(32767, 1, 0), 0, '0});
    rows.push_back('{mk(-1, -32767, 0), 0, '0});
    rows.push_back('{mk(1, 0, 1), 0, '0});
    rows.push_back('{mk(16'h5555, 16'haaaa, 1), 0, '0});
    rows.push_back('{mk(16'haaaa, 16'h5555, 1), 0, '0});
    rows.push_back('{mk(0, 32767, 1), 0, '0});
    rows.push_back('{mk(0, 0, 1), 0, '0});
    foreach (rows[i]) send_pair(rows[i].it, rows[i].typed, rows[i].res);
    drain();

    // mono: right sample ignored
    reg_write(REG_MONO, 32'h1);
    send_pair(mk(-32768, 5, 0), 0, '0);
    send_pair(mk(100, -32768, 1), 0, '0);
    send_pair(mk(0, 32767, 1), 0, '0);
    drain();
    // extremes: gain full, decay 2560, then gain zero, decay zero
    reg_write(REG_MONO, 32'h0);
    reg_write(REG_GAIN, 32'hffff);
    reg_write(REG_DECAY, 32'd2560);
    for (int i = 0; i < 14; i++) send_pair(mk(i[0] ? 32767 : 0, 0, 1), 0, '0);
    drain();
    reg_write(REG_GAIN, 32'h0);
    reg_write(REG_DECAY, 32'h0);
    send_pair(mk(-32768, 32767, 1), 0, '0);
    drain();

    // random phases across settings; upper data bits exercised too
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_GAIN, (ph == 4) ? 32'hffff_ffff : $urandom);
      reg_write(REG_DECAY, (ph == 0) ? 32'd2560 : $urandom_range(0, 2560));
      reg_write(REG_MONO, $urandom_range(0, 1));
      for (int f = 0; f < 23; f++) random_frame(12);
      drain();
    end
    // one longer frame ended by the marker
    reg_write(REG_GAIN, GAIN_RST);
    reg_write(REG_DECAY, DECAY_RST);
    reg_write(REG_MONO, 32'h0);
    random_frame(60);
    drain();
    if (errors == 0) $display("stereo_vu_level_meter regression: pass");
    else $display("stereo_vu_level_meter regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("stereo_vu_level_meter regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/svu_pkg.sv
rtl/core/svu_ctrl.sv
rtl/core/svu_dp.sv
rtl/core/stereo_vu_level_meter.sv
rtl/core/svu_checker.sv
tb/stereo_vu_level_meter_test.sv
